>>> sv/gwm_pkg.sv
// Shared types and constants for the glob wildcard matcher.
// Used by gwm_cfg, gwm_step and glob_wildcard_matcher; no dependencies.
package gwm_pkg;

	// Fixed register geometry
	localparam int PAT_BYTES  = 16;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

	// Special byte codes
	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] ANY_BYTE  = 8'h3F;
	localparam logic [7:0] DOT_BYTE  = 8'h2E;
	localparam logic [7:0] END_BYTE  = 8'h00;

	// Pattern as seen by the matching logic; len already clamped
	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          len;
	} pat_cfg_t;

endpackage

>>> sv/gwm_cfg.sv
// Pattern configuration registers with length clamp.
// Depends on gwm_pkg.
module gwm_cfg #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gwm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output gwm_pkg::pat_cfg_t                pat
);

	logic [gwm_pkg::CFG_DATA_W-1:0] pat_low_q;
	logic [gwm_pkg::CFG_DATA_W-1:0] pat_high_q;
	logic [gwm_pkg::LEN_W-1:0]      len_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			len_q      <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gwm_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				gwm_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				gwm_pkg::REG_PAT_LEN:  len_q      <= cfg_data[gwm_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Byte 0 sits in the low bits of the low word
	assign pat.bytes = {pat_high_q, pat_low_q};
	assign pat.len   = (len_q > gwm_pkg::LEN_W'(PATTERN_MAX)) ?
		gwm_pkg::LEN_W'(PATTERN_MAX) : len_q;

endmodule

>>> sv/gwm_close.sv
// Star closure of an active-position vector as a log-depth prefix scan.
// No package dependencies.
module gwm_close #(
	parameter int PATTERN_MAX = 16
) (
	input  logic [PATTERN_MAX:0]   v,
	input  logic [PATTERN_MAX:0]   mask,
	input  logic [PATTERN_MAX-1:0] star,
	output logic [PATTERN_MAX:0]   closed
);

	localparam int LEVELS = $clog2(PATTERN_MAX + 1);

	// A set bit at i carries to i+1 when position i is a star:
	// closed[i] = (v[i] & mask[i]) | (closed[i-1] & star[i-1]), done Kogge-Stone style.
	always_comb begin
		logic [PATTERN_MAX:0] g;
		logic [PATTERN_MAX:0] p;
		g = v & mask;
		p = {star, 1'b0};
		for (int k = 0; k < LEVELS; k++) begin
			g = g | (p & (g << (1 << k)));
			p = p & (p << (1 << k));
		end
		closed = g;
	end

endmodule

>>> sv/gwm_step.sv
// One NFA step: close the state, advance on a text byte, close again.
// Depends on gwm_pkg and gwm_close.
module gwm_step #(
	parameter int PATTERN_MAX = 16
) (
	input  gwm_pkg::pat_cfg_t      pat,
	input  logic [PATTERN_MAX:0]   state,
	input  logic [7:0]             text_byte,
	output logic [PATTERN_MAX:0]   next_state,
	output logic                   matched
);

	logic [PATTERN_MAX:0]   mask;
	logic [PATTERN_MAX:0]   len_sel;
	logic [PATTERN_MAX-1:0] star;
	logic [PATTERN_MAX-1:0] hit;
	logic [PATTERN_MAX:0]   cur;
	logic [PATTERN_MAX:0]   adv;

	// Per-position decode of the pattern against this byte
	always_comb begin
		for (int i = 0; i <= PATTERN_MAX; i++) begin
			mask[i]    = gwm_pkg::LEN_W'(i) <= pat.len;
			len_sel[i] = gwm_pkg::LEN_W'(i) == pat.len;
		end
		for (int i = 0; i < PATTERN_MAX; i++) begin
			star[i] = (gwm_pkg::LEN_W'(i) < pat.len) && (pat.bytes[i] == gwm_pkg::STAR_BYTE);
			hit[i]  = (gwm_pkg::LEN_W'(i) < pat.len) && !star[i] &&
				((pat.bytes[i] == text_byte) ||
				 ((pat.bytes[i] == gwm_pkg::ANY_BYTE) && (text_byte != gwm_pkg::DOT_BYTE)));
		end
	end

	gwm_close #(.PATTERN_MAX(PATTERN_MAX)) u_close_cur (
		.v      (state),
		.mask   (mask),
		.star   (star),
		.closed (cur)
	);

	// Stars hold their position, matching bytes move one on
	assign adv = ({1'b0, cur[PATTERN_MAX-1:0] & star}) |
		({cur[PATTERN_MAX-1:0] & hit, 1'b0});

	gwm_close #(.PATTERN_MAX(PATTERN_MAX)) u_close_adv (
		.v      (adv),
		.mask   (mask),
		.star   (star),
		.closed (next_state)
	);

	assign matched = |(cur & len_sel);

endmodule

>>> sv/glob_wildcard_matcher.sv
// Glob wildcard matcher top level: input register, NFA step, result register.
// Depends on gwm_pkg, gwm_cfg, gwm_close and gwm_step.
//
// Usage: text arrives one byte per word on in_valid/in_stall/text_byte.
// Bytes other than zero give no result; a zero byte ends the string and
// gives one word on out_valid/out_stall/matched, 1 when the whole text
// matched the pattern ('*' any run, '?' any byte but '.', else exact).
// The pattern is written through cfg_wr_en/cfg_index/cfg_data while no
// string is in flight: index 0 bytes 0..7, 1 bytes 8..15, 2 the length.
// Throughput: one byte per cycle while in_stall is low. The active-position
// vector is updated combinationally (closure, advance, closure) and fed
// back, so that loop sets the rate. An accepted byte is held in the input
// register and stepped from there; an end byte loads the result register,
// and the result is offered from then on.
// Reset clears the pattern to empty and the state to the start position.
// A stalled result holds; nonzero bytes keep flowing under it, while an
// end byte waits in the input register and in_stall rises until the
// pending result is taken.
module glob_wildcard_matcher #(
	parameter int PATTERN_MAX = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [gwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gwm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       text_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             matched
);

	localparam logic [PATTERN_MAX:0] START_STATE = (PATTERN_MAX+1)'(1);

	gwm_pkg::pat_cfg_t    pat;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 is_end_s1;
	logic                 go_s1;
	logic [PATTERN_MAX:0] state_q;
	logic [PATTERN_MAX:0] next_state;
	logic                 step_matched;
	logic                 out_valid_q;
	logic                 matched_q;

	gwm_cfg #(.PATTERN_MAX(PATTERN_MAX)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pat       (pat)
	);

	// Stage 1 drains unless it holds an end byte facing a stuck result
	assign is_end_s1 = byte_s1 == gwm_pkg::END_BYTE;
	assign go_s1     = valid_s1 && (!is_end_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
		end
	end

	gwm_step #(.PATTERN_MAX(PATTERN_MAX)) u_step (
		.pat        (pat),
		.state      (state_q),
		.text_byte  (byte_s1),
		.next_state (next_state),
		.matched    (step_matched)
	);

	// Active positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= START_STATE;
		end else if (go_s1) begin
			state_q <= is_end_s1 ? START_STATE : next_state;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && is_end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_end_s1) begin
			matched_q <= step_matched;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

	// An end of string always restarts the NFA
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s1 && is_end_s1) |=> (state_q == START_STATE))
		else $error("state not restarted after end byte");

	// Input backs up only behind an end byte blocked by a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && is_end_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked end byte");

	// A new result only comes from an end byte stepping through
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(go_s1 && is_end_s1))
		else $error("result appeared without an end byte");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for glob_wildcard_matcher: streams text words against configured patterns and
// checks every match word against an NFA predictor kept in the bench. Needs gwm_pkg and the RTL.
module tb;

	localparam int CLK_HALF    = 4;
	localparam int RST_CYCLES  = 7;
	localparam int LIMIT       = 200000;
	localparam int SETTLE      = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int TEXT_MAX    = 64;
	localparam int MATCH_DEPTH = 64;
	localparam int PHASE_BYTES = 75;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gwm_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_stall;
	logic [7:0]                     text_byte;
	logic                           out_valid;
	logic                           out_stall;
	logic                           matched;

	// Predictor copy of the registers and the active-position vector
	logic [63:0] pat_low;
	logic [63:0] pat_high;
	logic [4:0]  pat_len;
	logic [16:0] active_pos;
	logic        exp_match;

	// Expected match words, written by the sender, read by the checker
	logic        match_buf [MATCH_DEPTH];
	int unsigned match_wr;
	int unsigned match_rd = 0;

	// Text of the string being built
	logic [7:0]  text_buf [TEXT_MAX];
	int unsigned text_len;

	// Pacing knobs and counters
	int unsigned gap_max;
	int unsigned stall_pct;
	int unsigned hold_req;
	int unsigned burst_left;
	int unsigned cycle_cnt = 0;
	int unsigned errors = 0;
	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned results_seen = 0;
	int unsigned n_settings;

	glob_wildcard_matcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.text_byte (text_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.matched   (matched)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("Timeout after %0d cycles, %0d match words outstanding", cycle_cnt,
				match_wr - match_rd);
			$display("TEST FAILED");
			$finish;
		end
	end

	// ---------------- NFA predictor ----------------

	// length register clamped to the pattern size
	function automatic int unsigned used_len();
		int unsigned n;
		n = 32'(pat_len);
		if (n > gwm_pkg::PAT_BYTES)
			n = gwm_pkg::PAT_BYTES;
		return n;
	endfunction

	function automatic logic [7:0] pat_byte(input int unsigned pos);
		if (pos < 8)
			return pat_low[pos*8 +: 8];
		return pat_high[(pos-8)*8 +: 8];
	endfunction

	// drop positions past the length, then let every reached star also reach the next position
	function automatic logic [16:0] star_close(input logic [16:0] v, input int unsigned len);
		logic [16:0] r;
		int unsigned i;
		r = v;
		for (i = 0; i <= 16; i++)
			if (i > len)
				r[i] = 1'b0;
		for (i = 0; i < len; i++)
			if (r[i] && pat_byte(i) == gwm_pkg::STAR_BYTE)
				r[i+1] = 1'b1;
		return r;
	endfunction

	function automatic logic [16:0] advance_on(input logic [16:0] v, input int unsigned len,
		input logic [7:0] c);
		logic [16:0] nxt;
		logic [7:0]  p;
		int unsigned i;
		nxt = '0;
		for (i = 0; i < len; i++) begin
			if (v[i]) begin
				p = pat_byte(i);
				if (p == gwm_pkg::STAR_BYTE)
					nxt[i] = 1'b1;
				else if (p == c || (p == gwm_pkg::ANY_BYTE && c != gwm_pkg::DOT_BYTE))
					nxt[i+1] = 1'b1;
			end
		end
		return nxt;
	endfunction

	// one accepted text word; an end word queues the expected match bit
	function automatic void nfa_step(input logic [7:0] c);
		int unsigned len;
		logic [16:0] cur;
		len = used_len();
		cur = star_close(active_pos, len);
		if (c == gwm_pkg::END_BYTE) begin
			match_buf[match_wr % MATCH_DEPTH] = cur[len];
			match_wr++;
			active_pos = 17'd1;
		end else begin
			active_pos = star_close(advance_on(cur, len, c), len);
		end
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH cycle %0d: %s", cycle_cnt, what);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (match_wr == match_rd) begin
				report_mismatch("match word with no string ended");
			end else begin
				exp_match = match_buf[match_rd % MATCH_DEPTH];
				match_rd++;
				results_seen++;
				if (matched !== exp_match)
					report_mismatch($sformatf("string %0d: matched %b, expected %b",
						results_seen, matched, exp_match));
			end
		end
	end

	// Receiver: stall in runs of random length, or a long hold-off on request
	initial begin : rx_stall_gen
		int unsigned run_left;
		int unsigned holds_done;
		logic        run_stall;
		run_left   = 0;
		holds_done = 0;
		run_stall  = 1'b0;
		out_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (run_left == 0) begin
					run_left  = $urandom_range(1, 12);
					run_stall = ($urandom_range(0, 99) < stall_pct);
				end
				run_left--;
				out_stall <= run_stall;
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	// offer one word, with a random gap at the start of each burst
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
		nfa_step(b);
	endtask

	function automatic void add_text_byte(input logic [7:0] b);
		if (text_len < TEXT_MAX) begin
			text_buf[text_len] = b;
			text_len++;
		end
	endfunction

	task automatic send_string();
		int unsigned i;
		for (i = 0; i < text_len; i++)
			send_byte(text_buf[i]);
		send_byte(gwm_pkg::END_BYTE);
		strings_sent++;
	endtask

	task automatic send_text(input string s);
		int i;
		text_len = 0;
		for (i = 0; i < s.len(); i++)
			add_text_byte(s[i]);
		send_string();
	endtask

	// all match words in and the last word stepped
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (match_wr != match_rd)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_pattern(input logic [127:0] bytes, input logic [4:0] len);
		logic [63:0] d;
		d      = {$urandom, $urandom};
		d[4:0] = len;
		cfg_wr_en <= 1'b1;
		cfg_index <= gwm_pkg::REG_PAT_LOW;
		cfg_data  <= bytes[63:0];
		@(posedge clk);
		pat_low = bytes[63:0];
		cfg_index <= gwm_pkg::REG_PAT_HIGH;
		cfg_data  <= bytes[127:64];
		@(posedge clk);
		pat_high = bytes[127:64];
		cfg_index <= gwm_pkg::REG_PAT_LEN;
		cfg_data  <= d;
		@(posedge clk);
		pat_len = len;
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		n_settings++;
	endtask

	function automatic logic [127:0] pat_from_str(input string s);
		logic [127:0] r;
		int i;
		r = '0;
		for (i = 0; i < s.len() && i < gwm_pkg::PAT_BYTES; i++)
			r[i*8 +: 8] = s[i];
		return r;
	endfunction

	// nonzero text byte, biased toward the pattern alphabet
	function automatic logic [7:0] rand_text_byte();
		case ($urandom_range(0, 9))
			0, 1:    return "a";
			2:       return "b";
			3:       return gwm_pkg::DOT_BYTE;
			4:       return gwm_pkg::STAR_BYTE;
			5:       return gwm_pkg::ANY_BYTE;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_pat_byte();
		case ($urandom_range(0, 9))
			0, 1, 2: return gwm_pkg::STAR_BYTE;
			3:       return gwm_pkg::ANY_BYTE;
			4:       return gwm_pkg::DOT_BYTE;
			5, 6:    return "a";
			7:       return "b";
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// text that follows the current pattern, optionally with one byte spoiled
	task automatic build_text(input bit spoil);
		int unsigned len, i, j, k;
		logic [7:0] p;
		logic [7:0] t;
		text_len = 0;
		len = used_len();
		for (i = 0; i < len; i++) begin
			p = pat_byte(i);
			if (p == gwm_pkg::STAR_BYTE) begin
				repeat ($urandom_range(0, 3)) add_text_byte(rand_text_byte());
			end else if (p == gwm_pkg::ANY_BYTE) begin
				t = rand_text_byte();
				add_text_byte((t == gwm_pkg::DOT_BYTE) ? 8'h61 : t);
			end else if (p == gwm_pkg::END_BYTE) begin
				add_text_byte(rand_text_byte());
			end else begin
				add_text_byte(p);
			end
		end
		if (spoil) begin
			if (text_len == 0 || $urandom_range(0, 2) == 0) begin
				add_text_byte(rand_text_byte());
			end else begin
				k = $urandom_range(0, text_len - 1);
				if ($urandom_range(0, 1) == 0) begin
					text_buf[k] = rand_text_byte();
				end else begin
					for (j = k; j + 1 < text_len; j++)
						text_buf[j] = text_buf[j+1];
					text_len--;
				end
			end
		end
	endtask

	// ---------------- tests ----------------

	// reset leaves an empty pattern: only the empty text matches
	task automatic test_reset_state();
		send_text("");
		send_text("a");
	endtask

	task automatic test_wildcards();
		wait_idle();
		set_pattern(pat_from_str("*?."), 5'd3);
		send_text("x.");
		// '?' refuses a dot
		send_text("..");
	endtask

	// all-ones byte, and a zero byte used as a literal that can never match
	task automatic test_literal_extremes();
		logic [127:0] p;
		wait_idle();
		p = '1;
		p[15:8] = 8'h00;
		set_pattern(p, 5'd2);
		text_len = 0;
		add_text_byte(8'hFF);
		send_string();
	endtask

	// length above the pattern size is clamped; last byte sits in the high word
	task automatic test_long_length();
		logic [127:0] p;
		int i;
		wait_idle();
		for (i = 0; i < gwm_pkg::PAT_BYTES - 1; i++)
			p[i*8 +: 8] = gwm_pkg::STAR_BYTE;
		p[127:120] = 8'h80;
		set_pattern(p, 5'd31);
		text_len = 0;
		add_text_byte(8'h80);
		send_string();
	endtask

	// pattern rewritten while a string is open: state kept, read against the new pattern
	task automatic test_mid_string_change();
		wait_idle();
		set_pattern(pat_from_str("abc"), 5'd3);
		send_byte("a");
		send_byte("b");
		wait_idle();
		set_pattern(pat_from_str("abc"), 5'd1);
		send_byte(gwm_pkg::END_BYTE);
		wait_idle();
		set_pattern(pat_from_str("ab"), 5'd2);
		send_byte("a");
		wait_idle();
		set_pattern(pat_from_str("a*"), 5'd2);
		send_byte("z");
		send_byte(gwm_pkg::END_BYTE);
	endtask

	task automatic test_random_phases();
		int unsigned ph, start, r, len, i;
		logic [127:0] p;
		for (ph = 0; ph < 8; ph++) begin
			wait_idle();
			for (i = 0; i < gwm_pkg::PAT_BYTES; i++)
				p[i*8 +: 8] = rand_pat_byte();
			case (ph)
				0:       len = gwm_pkg::PAT_BYTES;
				1:       len = 0;
				2:       len = $urandom_range(17, 31);
				3:       len = 1;
				default: len = $urandom_range(2, 8);
			endcase
			set_pattern(p, len[4:0]);
			case (ph)
				0: begin
					gap_max   = 0;
					stall_pct = 0;
				end
				1: begin
					gap_max   = 8;
					stall_pct = 50;
				end
				default: begin
					gap_max   = $urandom_range(0, 6);
					stall_pct = $urandom_range(0, 60);
				end
			endcase
			start = bytes_sent;
			while (bytes_sent - start < PHASE_BYTES) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					build_text(1'b0);
				end else if (r < 8) begin
					build_text(1'b1);
				end else begin
					text_len = 0;
					repeat ($urandom_range(0, 10)) add_text_byte(rand_text_byte());
				end
				send_string();
			end
		end
	endtask

	// receiver holds off while short strings keep coming, so the input backs up
	task automatic test_receiver_holdoff();
		int i;
		wait_idle();
		set_pattern(pat_from_str("*a"), 5'd2);
		gap_max   = 0;
		stall_pct = 0;
		hold_req++;
		for (i = 0; i < 20; i++)
			send_text((i % 2) ? "ba" : "b");
	endtask

	initial begin
		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = gwm_pkg::REG_PAT_LOW;
		cfg_data   = '0;
		in_valid   = 1'b0;
		text_byte  = '0;
		pat_low    = '0;
		pat_high   = '0;
		pat_len    = '0;
		active_pos = 17'd1;
		match_wr   = 0;
		text_len   = 0;
		gap_max    = 3;
		stall_pct  = 30;
		hold_req   = 0;
		burst_left = 0;
		bytes_sent = 0;
		strings_sent = 0;
		n_settings = 0;
		repeat (RST_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_wildcards();
		test_literal_extremes();
		test_long_length();
		test_mid_string_change();
		test_random_phases();
		test_receiver_holdoff();

		wait_idle();
		repeat (20) @(posedge clk);
		$display("Covered %0d text words in %0d strings over %0d pattern settings; %0d checked.",
			bytes_sent, strings_sent, n_settings, results_seen);
		$display("Pacing: sender bursts and gaps, receiver stall runs, one long hold-off.");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
